// ----- hw/rtl/frame_resampler_mixer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Frame resampler mixer assertion macros
// Concurrent assertion helpers for the frame resampler mixer core. Defining
// ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef FRAME_RESAMPLER_MIXER_CORE_ASSERT_SVH
`define FRAME_RESAMPLER_MIXER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define FRM_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("frame resampler mixer check failed");

`define FRM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("frame resampler mixer check failed");

`else

`define FRM_ASSERT_SAME(label, clk, rst_n, pre, post)

`define FRM_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- hw/rtl/frm_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer package
// Shared widths, reset values, register indexes and payload types.
// ----------------------------------------------------------------------------
package frm_pkg;

	localparam int SAMPLE_W = 8;
	localparam int RATE_W = 17;
	localparam int LEN_W = 14;
	localparam int ACC_W = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam int MAX_FRAME_SAMPLES_DEF = 8192;
	localparam int MAX_EMITS_PER_INPUT_DEF = 8;

	localparam logic [RATE_W-1:0] OUT_RATE_RST = RATE_W'(48000);
	localparam logic [RATE_W-1:0] SRC_STEP_RST = RATE_W'(31440);
	localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = LEN_W'(800);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUT_RATE,
		REG_SRC_STEP,
		REG_FRAME_LENGTH,
		REG_MIX_ENABLE
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] tone_sample;
		logic [SAMPLE_W-1:0] aux_sample;
		logic frame_start;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_sample;
		logic frame_last;
	} out_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] out_rate;
		logic [RATE_W-1:0] src_step;
		logic [LEN_W-1:0] frame_length;
		logic mix_enable;
	} cfg_t;

	typedef enum logic {
		OP_ADD,
		OP_SUB
	} unit_op_t;

	typedef struct packed {
		unit_op_t op;
		logic [ACC_W-1:0] a;
		logic [RATE_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] res;
		logic flag;
	} unit_rsp_t;

endpackage

// ----- hw/rtl/frm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer configuration registers
// Decodes register write requests and holds the masked register values.
// ----------------------------------------------------------------------------
module frm_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data,
	output frm_pkg::cfg_t cfg
);
	import frm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_rate <= OUT_RATE_RST;
			cfg_q.src_step <= SRC_STEP_RST;
			cfg_q.frame_length <= FRAME_LENGTH_RST;
			cfg_q.mix_enable <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OUT_RATE: begin
					cfg_q.out_rate <= cfg_data[RATE_W-1:0];
				end
				REG_SRC_STEP: begin
					cfg_q.src_step <= cfg_data[RATE_W-1:0];
				end
				REG_FRAME_LENGTH: begin
					cfg_q.frame_length <= cfg_data[LEN_W-1:0];
				end
				REG_MIX_ENABLE: begin
					cfg_q.mix_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/frm_acc_unit.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer accumulator unit
// Shared adder for the phase accumulator: saturating add, or subtract with
// borrow used as the compare result.
// ----------------------------------------------------------------------------
module frm_acc_unit (
	input  frm_pkg::unit_req_t req,
	output frm_pkg::unit_rsp_t rsp
);
	import frm_pkg::*;

	logic [ACC_W:0] sum;
	logic [ACC_W:0] diff;

	assign sum = {1'b0, req.a} + {2'b00, req.b};
	assign diff = {1'b0, req.a} - {2'b00, req.b};

	always_comb begin
		case (req.op)
			OP_ADD: begin
				rsp.res = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
				rsp.flag = sum[ACC_W];
			end
			OP_SUB: begin
				rsp.res = diff[ACC_W-1:0];
				rsp.flag = diff[ACC_W];
			end
			default: begin
				rsp.res = sum[ACC_W-1:0];
				rsp.flag = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/frm_seq.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer sequencer
// Steps one source sample through accumulate and emit cycles, driving the
// shared accumulator unit and the registered output.
// ----------------------------------------------------------------------------
module frm_seq #(
	parameter int MAX_FRAME_SAMPLES = frm_pkg::MAX_FRAME_SAMPLES_DEF,
	parameter int MAX_EMITS_PER_INPUT = frm_pkg::MAX_EMITS_PER_INPUT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  frm_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  frm_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output frm_pkg::out_item_t out_data,
	output frm_pkg::unit_req_t unit_req,
	input  frm_pkg::unit_rsp_t unit_rsp
);
	import frm_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int EMIT_W = $clog2(MAX_EMITS_PER_INPUT + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] count_q;
	logic [EMIT_W-1:0] emits_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic start_q;
	logic out_valid_q;
	out_item_t out_data_q;

	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] max_ext;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] count_inc;
	logic [SAMPLE_W:0] mix_sum;
	logic emit_ok;
	logic out_free;
	logic emit_fire;

	assign len_ext = CMP_W'(cfg.frame_length);
	assign max_ext = CMP_W'(MAX_FRAME_SAMPLES);
	assign limit = (len_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(len_ext);
	assign count_inc = count_q + CNT_W'(1);
	assign mix_sum = {1'b0, in_data.tone_sample} + {1'b0, in_data.aux_sample};

	assign emit_ok = !unit_rsp.flag && (count_q < limit)
		&& (emits_q < EMIT_W'(MAX_EMITS_PER_INPUT));
	assign out_free = !out_valid_q || out_ready;
	assign emit_fire = (state_q == ST_EMIT) && emit_ok && out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		unit_req.a = acc_q;
		if (state_q == ST_ADD) begin
			unit_req.op = OP_ADD;
			unit_req.b = cfg.out_rate;
		end else begin
			unit_req.op = OP_SUB;
			unit_req.b = cfg.src_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= '0;
			count_q <= CNT_W'(MAX_FRAME_SAMPLES);
			emits_q <= '0;
			sample_q <= '0;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= cfg.mix_enable ? mix_sum[SAMPLE_W:1]
							: in_data.tone_sample;
						start_q <= in_data.frame_start;
						emits_q <= '0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (start_q) begin
						acc_q <= ACC_W'(cfg.out_rate);
						count_q <= '0;
					end else begin
						acc_q <= unit_rsp.res;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!emit_ok) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						acc_q <= unit_rsp.res;
						count_q <= count_inc;
						emits_q <= emits_q + EMIT_W'(1);
						out_data_q.out_sample <= sample_q;
						out_data_q.frame_last <= (count_inc == limit);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/frame_resampler_mixer_core.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer core
// Nearest-neighbor sample-rate converter with an optional two-chip average.
// ----------------------------------------------------------------------------
// Each source request is accepted, then the phase accumulator is updated, then
// each output sample it produces (at most MAX_EMITS_PER_INPUT) is emitted, and
// a final pass through the emit state ends the emit loop. The accumulate and
// emit steps share one accumulator adder; an emit waits while the output
// register holds a sample that is not yet taken. The next request is taken
// while the last output still waits in the output register. Configuration
// registers are out_rate (index 0, reset 48000), src_step (index 1, reset
// 31440), frame_length (index 2, reset 800) and mix_enable (index 3, reset 0),
// and must be written only while the core is idle; the core does not enforce
// this. No output is produced until the first request that marks a frame start.
module frame_resampler_mixer_core #(
	parameter int MAX_FRAME_SAMPLES = frm_pkg::MAX_FRAME_SAMPLES_DEF,
	parameter int MAX_EMITS_PER_INPUT = frm_pkg::MAX_EMITS_PER_INPUT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  frm_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output frm_pkg::out_item_t out_data
);
	import frm_pkg::*;

	cfg_t cfg;
	unit_req_t unit_req;
	unit_rsp_t unit_rsp;

	assign cfg_ready = 1'b1;

	frm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	frm_acc_unit u_acc_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	frm_seq #(
		.MAX_FRAME_SAMPLES   (MAX_FRAME_SAMPLES),
		.MAX_EMITS_PER_INPUT (MAX_EMITS_PER_INPUT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.unit_req  (unit_req),
		.unit_rsp  (unit_rsp)
	);

`include "frame_resampler_mixer_core_assert.svh"

	`FRM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`FRM_ASSERT_NEXT(a_mix_write, clk, arst_n,
		cfg_valid && cfg_ready && (cfg_index == REG_MIX_ENABLE),
		cfg.mix_enable == $past(cfg_data[0]))
	`FRM_ASSERT_NEXT(a_rate_write, clk, arst_n,
		cfg_valid && cfg_ready && (cfg_index == REG_OUT_RATE),
		cfg.out_rate == $past(cfg_data[RATE_W-1:0]))
	`FRM_ASSERT_SAME(a_unit_add_only_busy, clk, arst_n, unit_req.op == OP_ADD, !in_ready)

endmodule

// ----- test/tb_frame_resampler_mixer_core.sv -----
// ----------------------------------------------------------------------------
// Frame resampler mixer core testbench
// Drives source requests and register writes into the core and checks every
// output sample against hand-set values for typed plan rows, else against
// an in-bench model of the phase accumulator, frame counter and two-chip
// average. A directed plan precedes random phases with fresh register
// settings, random request and output idling, and a final idle-free stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_frame_resampler_mixer_core;

	import frm_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_EMITS = MAX_EMITS_PER_INPUT_DEF;
	localparam int MAX_FRAME = MAX_FRAME_SAMPLES_DEF;
	localparam logic [ACC_W-1:0] ACC_TOP = {ACC_W{1'b1}};

	typedef struct {
		bit is_cfg;
		cfg_reg_t idx;
		logic [CFG_DATA_W-1:0] data;
		in_item_t item;
		bit typed;
		int unsigned n_typed;
		out_item_t typed_out;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] step_q;
	logic [LEN_W-1:0] len_q;
	logic mix_q;
	logic [ACC_W-1:0] acc_q;
	logic [LEN_W-1:0] count_q;

	out_item_t pending_out[$];
	out_item_t step_emits[$];
	plan_row_t plan[$];

	int mismatch_count;
	int idle_cycles;
	bit calm;

	frame_resampler_mixer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void model_reset();
		rate_q = OUT_RATE_RST;
		step_q = SRC_STEP_RST;
		len_q = FRAME_LENGTH_RST;
		mix_q = 1'b0;
		acc_q = '0;
		count_q = LEN_W'(MAX_FRAME);
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_OUT_RATE: rate_q = data[RATE_W-1:0];
			REG_SRC_STEP: step_q = data[RATE_W-1:0];
			REG_FRAME_LENGTH: len_q = data[LEN_W-1:0];
			REG_MIX_ENABLE: mix_q = data[0];
			default: ;
		endcase
	endfunction

	function automatic void resample_step(in_item_t it);
		int unsigned lim;
		int unsigned n;
		logic [ACC_W:0] sum;
		logic [SAMPLE_W:0] pair;
		out_item_t o;
		step_emits.delete();
		lim = (len_q > MAX_FRAME) ? MAX_FRAME : len_q;
		if (it.frame_start) begin
			acc_q = ACC_W'(rate_q);
			count_q = '0;
		end else begin
			sum = {1'b0, acc_q} + (ACC_W + 1)'(rate_q);
			acc_q = (sum > {1'b0, ACC_TOP}) ? ACC_TOP : sum[ACC_W-1:0];
		end
		pair = {1'b0, it.tone_sample} + {1'b0, it.aux_sample};
		o.out_sample = mix_q ? pair[SAMPLE_W:1] : it.tone_sample;
		n = 0;
		while (n < MAX_EMITS && acc_q >= ACC_W'(step_q) && count_q < lim) begin
			acc_q = acc_q - ACC_W'(step_q);
			count_q = count_q + 1'b1;
			o.frame_last = (count_q == lim);
			step_emits.push_back(o);
			n++;
		end
	endfunction

	function automatic void add_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		r.item = '0;
		r.typed = 1'b0;
		r.n_typed = 0;
		r.typed_out = '0;
		plan.push_back(r);
	endfunction

	function automatic void add_item(logic [7:0] tone, logic [7:0] aux, logic start);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_OUT_RATE;
		r.data = '0;
		r.item = '{tone_sample: tone, aux_sample: aux, frame_start: start};
		r.typed = 1'b0;
		r.n_typed = 0;
		r.typed_out = '0;
		plan.push_back(r);
	endfunction

	function automatic void add_typed(logic [7:0] tone, logic [7:0] aux, logic start,
			int unsigned n, logic [7:0] smp, logic last);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_OUT_RATE;
		r.data = '0;
		r.item = '{tone_sample: tone, aux_sample: aux, frame_start: start};
		r.typed = 1'b1;
		r.n_typed = n;
		r.typed_out = '{out_sample: smp, frame_last: last};
		plan.push_back(r);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(in_item_t it, bit typed, int unsigned n_typed,
			out_item_t typed_out);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		resample_step(it);
		if (typed) begin
			repeat (n_typed) pending_out.push_back(typed_out);
		end else begin
			foreach (step_emits[i]) pending_out.push_back(step_emits[i]);
		end
	endtask

	task automatic random_phase(int unsigned n_items, bit wide);
		int unsigned st;
		int unsigned rt;
		in_item_t it;
		wait_drained();
		if (wide) begin
			write_reg(REG_OUT_RATE, CFG_DATA_W'($urandom));
			write_reg(REG_SRC_STEP, CFG_DATA_W'($urandom));
			write_reg(REG_FRAME_LENGTH, CFG_DATA_W'($urandom));
			write_reg(REG_MIX_ENABLE, CFG_DATA_W'($urandom));
		end else begin
			st = $urandom_range(1, 4000);
			rt = $urandom_range(st / 4 + 1, st * 9);
			write_reg(REG_OUT_RATE, CFG_DATA_W'(rt));
			write_reg(REG_SRC_STEP, CFG_DATA_W'(st));
			write_reg(REG_FRAME_LENGTH, CFG_DATA_W'($urandom_range(1, 48)));
			write_reg(REG_MIX_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
		end
		for (int unsigned k = 0; k < n_items; k++) begin
			it.tone_sample = 8'($urandom);
			it.aux_sample = 8'($urandom);
			if (k == 0)
				it.frame_start = ($urandom_range(0, 7) != 0);
			else
				it.frame_start = ($urandom_range(0, 9) == 0);
			send_sample(it, 1'b0, 0, '0);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int hold;
			@(posedge clk);
			if (calm) begin
				out_ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 14) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected output: sample %02h last %0b",
						out_data.out_sample, out_data.frame_last);
				mismatch_count++;
			end else begin
				want = pending_out.pop_front();
				if (want.out_sample !== out_data.out_sample ||
						want.frame_last !== out_data.frame_last) begin
					if (mismatch_count < 10)
						$display("output mismatch: expected %02h/%0b actual %02h/%0b",
							want.out_sample, want.frame_last,
							out_data.out_sample, out_data.frame_last);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_OUT_RATE;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		mismatch_count = 0;
		model_reset();

		add_typed(8'hFF, 8'h00, 1'b0, 0, 8'h00, 1'b0);
		add_typed(8'h00, 8'hFF, 1'b1, 1, 8'h00, 1'b0);
		add_item(8'hFF, 8'hFF, 1'b0);
		add_cfg(REG_MIX_ENABLE, 17'h1FFFF);
		add_typed(8'hFF, 8'hFF, 1'b1, 1, 8'hFF, 1'b0);
		add_item(8'hFF, 8'h01, 1'b0);
		add_cfg(REG_FRAME_LENGTH, 17'd1);
		add_typed(8'h12, 8'h34, 1'b1, 1, 8'h23, 1'b1);
		add_typed(8'h56, 8'h78, 1'b0, 0, 8'h00, 1'b0);
		add_cfg(REG_FRAME_LENGTH, 17'd0);
		add_typed(8'h9A, 8'hBC, 1'b1, 0, 8'h00, 1'b0);
		add_cfg(REG_OUT_RATE, 17'h1FFFF);
		add_cfg(REG_SRC_STEP, 17'd1);
		add_cfg(REG_FRAME_LENGTH, 17'h1FFFF);
		add_cfg(REG_MIX_ENABLE, 17'h1FFFE);
		add_typed(8'hAA, 8'h55, 1'b1, 8, 8'hAA, 1'b0);
		add_item(8'h55, 8'hAA, 1'b0);
		add_item(8'h01, 8'h80, 1'b0);
		add_item(8'h80, 8'h01, 1'b0);
		add_cfg(REG_OUT_RATE, 17'd0);
		add_cfg(REG_SRC_STEP, 17'd0);
		add_typed(8'h3C, 8'hC3, 1'b1, 8, 8'h3C, 1'b0);
		add_item(8'hC3, 8'h3C, 1'b0);
		add_cfg(REG_OUT_RATE, 17'd1);
		add_cfg(REG_SRC_STEP, 17'h1FFFF);
		add_typed(8'h0F, 8'hF0, 1'b1, 0, 8'h00, 1'b0);
		add_item(8'hF0, 8'h0F, 1'b0);
		add_item(8'h7F, 8'h80, 1'b0);
		add_cfg(REG_OUT_RATE, 17'd100);
		add_cfg(REG_SRC_STEP, 17'd30);
		add_cfg(REG_FRAME_LENGTH, 17'd5);
		add_cfg(REG_MIX_ENABLE, 17'd1);
		add_item(8'h00, 8'h00, 1'b1);
		add_item(8'hFF, 8'h00, 1'b0);
		add_item(8'h00, 8'hFF, 1'b0);
		add_item(8'hA5, 8'h5A, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg)
					wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_sample(plan[i].item, plan[i].typed, plan[i].n_typed,
					plan[i].typed_out);
			end
		end

		random_phase(30, 1'b1);
		for (int p = 0; p < 5; p++)
			random_phase(30, (p == 2));
		calm = 1'b1;
		random_phase(40, 1'b0);

		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_out.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
